[rtl/cgrm_pkg.sv]
// Package for the count-guided run merge core: beat types, entry layout,
// register and function codes, state enum and default sizes.
// No dependencies.
package cgrm_pkg;

  // Default sizes, overridable through top-level parameters
  localparam int unsigned MAX_RUNS_DEF  = 8;
  localparam int unsigned RUN_DEPTH_DEF = 1024;

  // Field widths
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned POS_W    = 14;
  localparam int unsigned RIDX_W   = 3;
  localparam int unsigned TBS_W    = 11;
  localparam int unsigned RIU_W    = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BLOCK_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUNS_IN_USE     = 1'd1;
  localparam logic [TBS_W-1:0] TBS_RESET = 11'd1024;
  localparam logic [RIU_W-1:0] RIU_RESET = 4'd8;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [RIDX_W-1:0]     run_index;
    logic [COUNT_W-1:0]    entry_count;
    logic [OFFSET_W-1:0]   entry_offset;
    logic [HEIGHT_W-1:0]   left_height;
    logic [HEIGHT_W-1:0]   right_height;
  } in_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_value;
    logic [HEIGHT_W-1:0]     height;
    logic                    height_valid;
    logic                    done_res;
  } out_beat_t;

  // One stored run entry
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [OFFSET_W-1:0] offset;
    logic [HEIGHT_W-1:0] left_height;
    logic [HEIGHT_W-1:0] right_height;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_EMIT
  } cgrm_state_e;

  localparam out_beat_t DONE_BEAT = '{
    position_value: '0,
    height:         '0,
    height_valid:   1'b0,
    done_res:       1'b1
  };

endpackage

[rtl/count_guided_run_merge_core.sv]
// Count-guided run merge core: run entry store, per-run counters, merge scan.
// Depends on cgrm_pkg and cgrm_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (in_beat_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (out_beat_t)
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A load beat is accepted, then written to the entry RAM in ST_LOAD if its run exists and is not full.
// A step beat scans runs in use (capped at MAX_RUNS) downward: a run with no unread
// entry is skipped, others are read, then compared; no hit or no run gives done.
// Reset clears fills, read positions, gap counters and the output stage; the
// entry RAM is not cleared, since only written entries are ever read.
// The output register holds a stalled result while the next beat is taken.
module count_guided_run_merge_core
  import cgrm_pkg::*;
#(
  parameter int unsigned MAX_RUNS  = MAX_RUNS_DEF,
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned RUN_W   = $clog2(MAX_RUNS);
  localparam int unsigned NRUN_W  = $clog2(MAX_RUNS + 1);
  localparam int unsigned FILL_W  = $clog2(RUN_DEPTH + 1);
  localparam int unsigned DEPTH   = MAX_RUNS * RUN_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SUM_W   = TBS_W + RUN_W + 2;

  // State and registers
  cgrm_state_e        state_q, state_d;
  logic [RUN_W-1:0]   idx_q, idx_d;
  in_beat_t           item_q, item_d;
  logic               load_ok_q, load_ok_d;
  logic [FILL_W-1:0]  fill_q  [MAX_RUNS];
  logic [FILL_W-1:0]  fill_d  [MAX_RUNS];
  logic [FILL_W-1:0]  rdpos_q [MAX_RUNS];
  logic [FILL_W-1:0]  rdpos_d [MAX_RUNS];
  logic [COUNT_W-1:0] gap_q   [MAX_RUNS];
  logic [COUNT_W-1:0] gap_d   [MAX_RUNS];
  logic [HEIGHT_W-1:0] last_rh_q, last_rh_d;
  logic               first_q, first_d;
  logic [TBS_W-1:0]   tbs_q;
  logic [RIU_W-1:0]   riu_q;
  out_beat_t          pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  // Datapath signals
  logic               in_acc;
  logic [NRUN_W-1:0]  n_runs;
  logic [FILL_W-1:0]  fill_sel, rdpos_sel, ptr_sel;
  logic [COUNT_W-1:0] gap_sel;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_we, ram_re;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t             head;
  logic [SUM_W-1:0]   pos_sum;
  logic [POS_W-1:0]   pos_neg;
  logic [HEIGHT_W-1:0] hmax;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Runs taking part, saturated to the number built
  assign n_runs = (32'(riu_q) > MAX_RUNS) ? NRUN_W'(MAX_RUNS) : NRUN_W'(riu_q);

  // Per-run control read at the current run index
  assign fill_sel  = fill_q[idx_q];
  assign rdpos_sel = rdpos_q[idx_q];
  assign gap_sel   = gap_q[idx_q];
  assign ptr_sel   = (state_q == ST_LOAD) ? fill_sel : rdpos_sel;
  assign ram_addr  = ADDR_W'(idx_q) * ADDR_W'(RUN_DEPTH) + ADDR_W'(ptr_sel);

  assign ram_we = (state_q == ST_LOAD) && load_ok_q && (32'(fill_sel) < RUN_DEPTH);
  assign ram_re = (state_q == ST_SCAN_RD) && (rdpos_sel < fill_sel);

  cgrm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i ({item_q.entry_count, item_q.entry_offset,
               item_q.left_height, item_q.right_height}),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign head = entry_t'(ram_rdata);

  // Result datapath: position and merged height of the head entry
  assign pos_sum = SUM_W'(idx_q) * SUM_W'(tbs_q) + SUM_W'(head.offset) + SUM_W'(1);
  assign pos_neg = ~pos_sum[POS_W-1:0] + POS_W'(1);
  assign hmax    = (last_rh_q > head.left_height) ? last_rh_q : head.left_height;

  // Next state and per-run updates
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    item_d      = item_q;
    load_ok_d   = load_ok_q;
    fill_d      = fill_q;
    rdpos_d     = rdpos_q;
    gap_d       = gap_q;
    last_rh_d   = last_rh_q;
    first_d     = first_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // output stage drains on accept
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          if (in_data_i.func == FUNC_LOAD) begin
            idx_d     = RUN_W'(in_data_i.run_index);
            load_ok_d = (32'(in_data_i.run_index) < MAX_RUNS);
            state_d   = ST_LOAD;
          end else if (n_runs == '0) begin
            pend_d  = DONE_BEAT;
            state_d = ST_EMIT;
          end else begin
            idx_d   = RUN_W'(n_runs - NRUN_W'(1));
            state_d = ST_SCAN_RD;
          end
        end
      end

      ST_LOAD: begin
        if (ram_we) begin
          fill_d[idx_q] = fill_sel + FILL_W'(1);
        end
        state_d = ST_IDLE;
      end

      ST_SCAN_RD: begin
        if (ram_re) begin
          state_d = ST_SCAN_CK;
        end else if (idx_q == '0) begin
          pend_d  = DONE_BEAT;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q - RUN_W'(1);
        end
      end

      ST_SCAN_CK: begin
        if (head.count == gap_sel) begin
          // hit: advance this run, bump gap counters of higher-indexed runs in use
          gap_d[idx_q] = '0;
          for (int j = 0; j < MAX_RUNS; j++) begin
            if (j > int'(idx_q) && j < int'(n_runs)) begin
              gap_d[j] = gap_q[j] + COUNT_W'(1);
            end
          end
          rdpos_d[idx_q]        = rdpos_sel + FILL_W'(1);
          last_rh_d             = head.right_height;
          first_d               = 1'b0;
          pend_d.position_value = $signed(pos_neg);
          pend_d.height         = first_q ? '0 : hmax;
          pend_d.height_valid   = !first_q;
          pend_d.done_res       = 1'b0;
          state_d               = ST_EMIT;
        end else if (idx_q == '0) begin
          pend_d  = DONE_BEAT;
          state_d = ST_EMIT;
        end else begin
          idx_d   = idx_q - RUN_W'(1);
          state_d = ST_SCAN_RD;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_rh_q   <= '0;
      first_q     <= 1'b1;
      tbs_q       <= TBS_RESET;
      riu_q       <= RIU_RESET;
      for (int r = 0; r < MAX_RUNS; r++) begin
        fill_q[r]  <= '0;
        rdpos_q[r] <= '0;
        gap_q[r]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_rh_q   <= last_rh_d;
      first_q     <= first_d;
      fill_q      <= fill_d;
      rdpos_q     <= rdpos_d;
      gap_q       <= gap_d;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEXT_BLOCK_SIZE: tbs_q <= cfg_wdata_i[TBS_W-1:0];
          REG_RUNS_IN_USE:     riu_q <= cfg_wdata_i[RIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    item_q    <= item_d;
    load_ok_q <= load_ok_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/cgrm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cgrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
